// ===== rtl/core/cs_pkg.sv =====
// Package for the comment stripper: item types, lexer modes and character codes.
`default_nettype none

package cs_pkg;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_STRING = 2'd1,
    MODE_LINE   = 2'd2,
    MODE_BLOCK  = 2'd3
  } cs_mode_t;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last;
  } cs_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       run_last;
    logic       stream_end;
  } cs_out_t;

  // All results caused by one input item.
  typedef struct packed {
    cs_out_t res0;
    cs_out_t res1;
    logic    two;
  } cs_entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/cs_lexer.sv =====
// Lexer state and the combinational step that turns one item into its results.
`default_nettype none

module cs_lexer (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              advance,
  input  wire cs_pkg::cs_in_t    item,
  output logic                   push,
  output cs_pkg::cs_entry_t      entry
);
  import cs_pkg::*;

  cs_mode_t   mode_r, mode_nxt;
  logic       quote_single_r, quote_single_nxt;
  logic       escape_r, escape_nxt;
  logic       slash_r, slash_nxt;
  logic       star_r, star_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_NORMAL;
      quote_single_r <= 1'b0;
      escape_r       <= 1'b0;
      slash_r        <= 1'b0;
      star_r         <= 1'b0;
    end else if (advance) begin
      mode_r         <= mode_nxt;
      quote_single_r <= quote_single_nxt;
      escape_r       <= escape_nxt;
      slash_r        <= slash_nxt;
      star_r         <= star_nxt;
    end
  end

  always_comb begin
    logic [7:0] b;
    logic       last;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [1:0] cnt;
    logic       do_normal;

    b         = item.in_byte;
    last      = item.last;
    byte0     = 8'h00;
    byte1     = 8'h00;
    cnt       = 2'd0;
    do_normal = 1'b0;

    mode_nxt         = mode_r;
    quote_single_nxt = quote_single_r;
    escape_nxt       = escape_r;
    slash_nxt        = slash_r;
    star_nxt         = star_r;

    unique case (mode_r)
      MODE_STRING: begin
        byte0 = b;
        cnt   = 2'd1;
        if (escape_r) begin
          escape_nxt = 1'b0;
        end else if (b == CH_BSLASH && !last) begin
          escape_nxt = 1'b1;
        end else if (b == (quote_single_r ? CH_SQUOTE : CH_DQUOTE)) begin
          mode_nxt = MODE_NORMAL;
        end
      end
      MODE_LINE: begin
        if (b == CH_NL) begin
          mode_nxt = MODE_NORMAL;
          byte0    = b;
          cnt      = 2'd1;
        end
      end
      MODE_BLOCK: begin
        if (star_r && b == CH_SLASH) begin
          mode_nxt = MODE_NORMAL;
          star_nxt = 1'b0;
        end else begin
          star_nxt = (b == CH_STAR);
        end
      end
      default: begin
        if (slash_r) begin
          slash_nxt = 1'b0;
          if (b == CH_SLASH) begin
            mode_nxt = MODE_LINE;
          end else if (b == CH_STAR) begin
            mode_nxt = MODE_BLOCK;
            star_nxt = 1'b0;
          end else begin
            byte0     = CH_SLASH;
            cnt       = 2'd1;
            do_normal = 1'b1;
          end
        end else begin
          do_normal = 1'b1;
        end
      end
    endcase

    if (do_normal) begin
      if (b == CH_DQUOTE || b == CH_SQUOTE) begin
        mode_nxt         = MODE_STRING;
        quote_single_nxt = (b == CH_SQUOTE);
        escape_nxt       = 1'b0;
        if (cnt == 2'd0) byte0 = b;
        else             byte1 = b;
        cnt = cnt + 2'd1;
      end else if (b == CH_SLASH && !last) begin
        slash_nxt = 1'b1;
      end else begin
        if (cnt == 2'd0) byte0 = b;
        else             byte1 = b;
        cnt = cnt + 2'd1;
      end
    end

    if (last && mode_nxt == MODE_BLOCK) begin
      if (cnt == 2'd0) byte0 = CH_SPACE;
      else             byte1 = CH_SPACE;
      cnt = cnt + 2'd1;
    end

    entry.res0.out_byte   = byte0;
    entry.res0.has_byte   = (cnt != 2'd0);
    entry.res0.run_last   = (cnt != 2'd2);
    entry.res0.stream_end = last && (cnt != 2'd2);
    entry.res1.out_byte   = byte1;
    entry.res1.has_byte   = 1'b1;
    entry.res1.run_last   = 1'b1;
    entry.res1.stream_end = last;
    entry.two             = (cnt == 2'd2);
    push                  = advance && (cnt != 2'd0 || last);

    if (last) begin
      mode_nxt         = MODE_NORMAL;
      quote_single_nxt = 1'b0;
      escape_nxt       = 1'b0;
      slash_nxt        = 1'b0;
      star_nxt         = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cs_result_fifo.sv =====
// Two-entry result queue that hands out the one or two results of each entry in turn.
`default_nettype none

module cs_result_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire cs_pkg::cs_entry_t entry,
  output logic                   can_push,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output cs_pkg::cs_out_t        out_data
);
  import cs_pkg::*;

  cs_entry_t  mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       sub_r, sub_nxt;
  logic       out_fire;
  logic       pop;
  cs_entry_t  head;

  assign head      = mem[rd_ptr_r];
  assign out_valid = (count_r != 2'd0);
  assign out_data  = sub_r ? head.res1 : head.res0;
  assign out_fire  = out_valid && out_ready;
  assign pop       = out_fire && (sub_r || !head.two);
  assign can_push  = (count_r != 2'd2) || pop;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
    sub_nxt    = sub_r;
    if (pop) begin
      sub_nxt = 1'b0;
    end else if (out_fire) begin
      sub_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
      sub_r    <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
      sub_r    <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= entry;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/comment_stripper.sv =====
// Top level of the comment stripper: input register, lexer and result queue.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   in_data  (in_byte, last)
//   out_     output     out_valid / out_ready out_data (out_byte, has_byte, run_last,
//                                                       stream_end)
//
// One item is taken per cycle while the queue has room; an item with two results hands
// them out one after the other, so a run of such items fills the queue and slows input.
// An item's first result is shown after the item is written into the result queue.
// Reset is synchronous and clears the lexer state and all valid flags.
// A stalled output fills the queue and then holds in_ready low without losing items.
`default_nettype none

module comment_stripper (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire cs_pkg::cs_in_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output cs_pkg::cs_out_t      out_data
);
  import cs_pkg::*;

  logic      in_valid_r;
  cs_in_t    in_item_r;
  logic      advance;
  logic      can_push;
  logic      push;
  cs_entry_t entry;

  assign advance  = in_valid_r && can_push;
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_data;
    end
  end

  cs_lexer u_lexer (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (in_item_r),
    .push    (push),
    .entry   (entry)
  );

  cs_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .entry     (entry),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/core/cs_checker.sv =====
// Port-level checks for the comment stripper and their binding to the top level.
`default_nettype none

module cs_port_checker (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            in_valid,
  input wire logic            in_ready,
  input wire cs_pkg::cs_in_t  in_data,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire cs_pkg::cs_out_t out_data
);
  import cs_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result item changed");

  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stream_end |-> out_data.run_last)
    else $error("stream end without run_last");

  a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.has_byte |->
      out_data.out_byte == 8'h00 && out_data.stream_end)
    else $error("bare end marker malformed");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("waiting input item changed");

endmodule

bind comment_stripper cs_port_checker u_cs_port_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
